[rtl/cpsp_pkg.sv]
// Shared types and constants of the cascaded position and speed PID unit.
// Used by the channel interfaces, the register file, the loop and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cpsp_pkg;

	localparam int FIELD_W     = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int GAINS_W  = 24;
	localparam int ILIM_W   = 31;
	localparam int LIMITS_W = 32;
	localparam int GAIN_W   = 8;
	localparam int LIMIT_W  = 16;
	localparam int KP_LSB   = 0;
	localparam int KI_LSB   = 8;
	localparam int KD_LSB   = 16;
	localparam int SPD_LSB  = 0;
	localparam int ACC_LSB  = 16;

	// Reciprocal of 100: (n * DIV100_MUL) >> DIV100_SHIFT is exact for every n < 2**32.
	localparam logic [31:0] DIV100_MUL   = 32'h51EB_851F;
	localparam int          DIV100_SHIFT = 37;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_POS_GAINS,
		REG_POS_ILIM,
		REG_POS_LIMITS,
		REG_SPD_GAINS,
		REG_SPD_ILIM,
		REG_SPD_LIMITS,
		REG_CASCADE
	} reg_index_t;

	typedef struct packed {
		logic [GAINS_W-1:0]  pos_gains;
		logic [ILIM_W-1:0]   pos_ilim;
		logic [LIMITS_W-1:0] pos_limits;
		logic [GAINS_W-1:0]  spd_gains;
		logic [ILIM_W-1:0]   spd_ilim;
		logic [LIMITS_W-1:0] spd_limits;
		logic                cascade;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/cpsp_if.sv]
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on cpsp_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface cpsp_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cpsp_pkg::FIELD_W-1:0] encoder_position;
	logic signed [cpsp_pkg::FIELD_W-1:0] target_position;

	modport source (output valid, output encoder_position, output target_position, input ready);
	modport sink (input valid, input encoder_position, input target_position, output ready);
endinterface

interface cpsp_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cpsp_pkg::FIELD_W-1:0] motor_command;
	logic signed [cpsp_pkg::FIELD_W-1:0] speed_reference;
	logic signed [cpsp_pkg::FIELD_W-1:0] measured_speed;

	modport source (output valid, output motor_command, output speed_reference,
		output measured_speed, input ready);
	modport sink (input valid, input motor_command, input speed_reference,
		input measured_speed, output ready);
endinterface

`default_nettype wire

[rtl/cpsp_regs.sv]
// Configuration register file: plain write port, no read-back.
// Depends on cpsp_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module cpsp_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [cpsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cpsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	output cpsp_pkg::cfg_t                     cfg
);
	import cpsp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{cascade: 1'b1, default: '0};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_POS_GAINS:  cfg_q.pos_gains  <= cfg_data[GAINS_W-1:0];
				REG_POS_ILIM:   cfg_q.pos_ilim   <= cfg_data[ILIM_W-1:0];
				REG_POS_LIMITS: cfg_q.pos_limits <= cfg_data[LIMITS_W-1:0];
				REG_SPD_GAINS:  cfg_q.spd_gains  <= cfg_data[GAINS_W-1:0];
				REG_SPD_ILIM:   cfg_q.spd_ilim   <= cfg_data[ILIM_W-1:0];
				REG_SPD_LIMITS: cfg_q.spd_limits <= cfg_data[LIMITS_W-1:0];
				REG_CASCADE:    cfg_q.cascade    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/cpsp_loop.sv]
// One PID loop as a five-stage pipeline: integrate, multiply, divide by 100,
// sum and clamp, slew. Depends on cpsp_pkg for field layout and constants.
`timescale 1ns / 1ps
`default_nettype none

module cpsp_loop #(
	parameter int DATA_WIDTH = 32,
	parameter int SIDE_W     = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              upd_en,
	input  logic [cpsp_pkg::GAINS_W-1:0]      gains,
	input  logic [cpsp_pkg::ILIM_W-1:0]       ilim,
	input  logic [cpsp_pkg::LIMITS_W-1:0]     limits,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [DATA_WIDTH-1:0]             in_err,
	input  logic [SIDE_W-1:0]                 in_side,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [DATA_WIDTH-1:0]             out_cmd,
	output logic [SIDE_W-1:0]                 out_side
);
	import cpsp_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int CW = ((W > ILIM_W) ? W : ILIM_W) + 2;
	localparam int NS = 5;

	logic signed [GAIN_W-1:0] kp, ki, kd;
	logic [LIMIT_W-1:0]       spd_lim, acc_lim;

	logic [NS:1]   vld;
	logic [NS:1]   vld_in;
	logic [NS+1:1] adv;
	logic          ld1, ld5;

	logic [W-1:0] prev_err_q, integ_q, prev_out_q;

	logic [W-1:0] err_s1, d_s1, integ_s1;
	logic [W-1:0] perr_s2, pint_s2, pd_s2;
	logic [W-1:0] psum_s3, quot_s3;
	logic         neg_s3;
	logic [W-1:0] cmd_s4, cmd_s5;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;

	logic [W-1:0]         d1, isum, inew;
	logic signed [CW-1:0] isum_x, ilim_x, integ_qx;
	logic signed [W+GAIN_W-1:0] m_err, m_int, m_d;
	logic [W-1:0]  mag;
	logic [63:0]   prod, qw;
	logic [W-1:0]  iterm, csum, cmd4;
	logic signed [CW-1:0] csum_x, spd_x;
	logic [W-1:0]  up, dn, slew;
	logic signed [CW-1:0] up_x, dn_x, acc_x;

	assign kp      = gains[KP_LSB +: GAIN_W];
	assign ki      = gains[KI_LSB +: GAIN_W];
	assign kd      = gains[KD_LSB +: GAIN_W];
	assign spd_lim = limits[SPD_LSB +: LIMIT_W];
	assign acc_lim = limits[ACC_LSB +: LIMIT_W];

	always_comb begin
		adv[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			adv[k] = !vld[k] || adv[k+1];
		end
	end

	assign vld_in   = {vld[NS-1:1], in_valid};
	assign in_ready = adv[1];
	assign ld1      = in_valid && adv[1];
	assign ld5      = vld[NS-1] && adv[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (adv[k]) vld[k] <= vld_in[k];
			end
		end
	end

	// integrate and clamp
	always_comb begin
		d1       = in_err - prev_err_q;
		isum     = integ_q + in_err;
		isum_x   = CW'(signed'(isum));
		ilim_x   = signed'(CW'(ilim));
		integ_qx = CW'(signed'(integ_q));
		inew     = isum;
		if (ki != '0) begin
			priority if (isum_x > ilim_x) inew = W'(ilim);
			else if (isum_x < -ilim_x)    inew = W'(-ilim_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (ld1 && upd_en) begin
			prev_err_q <= in_err;
			integ_q    <= inew;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			err_s1   <= in_err;
			d_s1     <= d1;
			integ_s1 <= inew;
			side_s1  <= in_side;
		end
	end

	// gain products
	always_comb begin
		m_err = signed'(err_s1) * kp;
		m_int = signed'(integ_s1) * ki;
		m_d   = signed'(d_s1) * kd;
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			perr_s2 <= m_err[W-1:0];
			pint_s2 <= m_int[W-1:0];
			pd_s2   <= m_d[W-1:0];
			side_s2 <= side_s1;
		end
	end

	// truncating divide by 100 on the magnitude
	always_comb begin
		mag  = pint_s2[W-1] ? -pint_s2 : pint_s2;
		prod = 64'(mag) * 64'(DIV100_MUL);
		qw   = prod >> DIV100_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			psum_s3 <= perr_s2 - pd_s2;
			quot_s3 <= qw[W-1:0];
			neg_s3  <= pint_s2[W-1];
			side_s3 <= side_s2;
		end
	end

	// sum and output clamp
	always_comb begin
		iterm  = neg_s3 ? -quot_s3 : quot_s3;
		csum   = psum_s3 + iterm;
		csum_x = CW'(signed'(csum));
		spd_x  = signed'(CW'(spd_lim));
		cmd4   = csum;
		if (spd_lim != '0) begin
			priority if (csum_x > spd_x) cmd4 = W'(spd_lim);
			else if (csum_x < -spd_x)    cmd4 = W'(-spd_x);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			cmd_s4  <= cmd4;
			side_s4 <= side_s3;
		end
	end

	// slew against the previous output
	always_comb begin
		up    = cmd_s4 - prev_out_q;
		dn    = prev_out_q - cmd_s4;
		up_x  = CW'(signed'(up));
		dn_x  = CW'(signed'(dn));
		acc_x = signed'(CW'(acc_lim));
		slew  = cmd_s4;
		if (acc_lim != '0) begin
			priority if (up_x > acc_x) slew = prev_out_q + W'(acc_lim);
			else if (dn_x > acc_x)     slew = prev_out_q - W'(acc_lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_out_q <= '0;
		end else if (ld5 && upd_en) begin
			prev_out_q <= slew;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			cmd_s5  <= slew;
			side_s5 <= side_s4;
		end
	end

	assign out_valid = vld[NS];
	assign out_cmd   = cmd_s5;
	assign out_side  = side_s5;

`ifndef SYNTH
	a_integ_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(ld1 && upd_en && ki != '0) |=>
		(integ_qx <= $past(ilim_x) && integ_qx >= -$past(ilim_x)))
		else $error("integral outside its clamp");

	a_prev_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(ld5 && upd_en) |=> $stable(prev_out_q))
		else $error("previous output changed without a slew stage load");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[NS] |-> in_ready)
		else $error("loop stalls input with an empty last stage");
`endif

endmodule

`default_nettype wire

[rtl/cascaded_position_speed_pid_unit.sv]
// Cascaded position and speed PID unit, top level.
// Depends on cpsp_pkg, cpsp_if, cpsp_regs and cpsp_loop.
//
// Each sample beat carries the encoder and target positions of one control
// tick and yields one result beat with the motor command, the limited speed
// reference and the measured speed. One beat is taken every clock cycle
// while the result channel accepts beats; each sample beat passes through
// the input stage register, then five stages for the position loop and five
// for the speed loop, before its result beat is presented.
// The integrator and slew registers of each loop feed back on themselves,
// which allows that rate. Arithmetic wraps at DATA_WIDTH bits; the 32-bit
// fields are truncated on entry and sign-extended on exit. Write the
// configuration registers only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_position_speed_pid_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [cpsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cpsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	cpsp_in_if.sink                            sample,
	cpsp_out_if.source                         result
);
	import cpsp_pkg::*;

	localparam int W = DATA_WIDTH;

	cfg_t cfg;

	logic         valid_s0, adv0, take;
	logic [W-1:0] pos_w, tgt_w;
	logic [W-1:0] prev_pos_q;
	logic [W-1:0] err_s0, speed_s0;

	logic         pos_valid, pos_ready, pos_in_ready;
	logic [W-1:0] sref, pos_side;
	logic [W-1:0] spd_err;
	logic [W-1:0] mcmd;
	logic [2*W-1:0] spd_side;
	logic [W-1:0] out_sref, out_motor;

	cpsp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign pos_w        = sample.encoder_position[W-1:0];
	assign tgt_w        = sample.target_position[W-1:0];
	assign adv0         = !valid_s0 || pos_in_ready;
	assign take         = sample.valid && adv0;
	assign sample.ready = adv0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0   <= 1'b0;
			prev_pos_q <= '0;
		end else begin
			if (adv0) valid_s0 <= sample.valid;
			if (take) prev_pos_q <= pos_w;
		end
	end

	always_ff @(posedge clk) begin
		if (adv0) begin
			err_s0   <= tgt_w - pos_w;
			speed_s0 <= pos_w - prev_pos_q;
		end
	end

	cpsp_loop #(
		.DATA_WIDTH (W),
		.SIDE_W     (W)
	) u_pos_loop (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (1'b1),
		.gains     (cfg.pos_gains),
		.ilim      (cfg.pos_ilim),
		.limits    (cfg.pos_limits),
		.in_valid  (valid_s0),
		.in_ready  (pos_in_ready),
		.in_err    (err_s0),
		.in_side   (speed_s0),
		.out_valid (pos_valid),
		.out_ready (pos_ready),
		.out_cmd   (sref),
		.out_side  (pos_side)
	);

	assign spd_err = sref - pos_side;

	cpsp_loop #(
		.DATA_WIDTH (W),
		.SIDE_W     (2 * W)
	) u_spd_loop (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (cfg.cascade),
		.gains     (cfg.spd_gains),
		.ilim      (cfg.spd_ilim),
		.limits    (cfg.spd_limits),
		.in_valid  (pos_valid),
		.in_ready  (pos_ready),
		.in_err    (spd_err),
		.in_side   ({sref, pos_side}),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_cmd   (mcmd),
		.out_side  (spd_side)
	);

	assign out_sref  = spd_side[2*W-1:W];
	assign out_motor = cfg.cascade ? mcmd : out_sref;

	assign result.motor_command   = FIELD_W'(signed'(out_motor));
	assign result.speed_reference = FIELD_W'(signed'(out_sref));
	assign result.measured_speed  = FIELD_W'(signed'(spd_side[W-1:0]));

`ifndef SYNTH
	a_prev_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample.valid && sample.ready) |=> $stable(prev_pos_q))
		else $error("previous position changed without a sample beat");
`endif

endmodule

`default_nettype wire

[verif/cascaded_position_speed_pid_unit_test.sv]
// Self-checking testbench of the cascaded position and speed PID unit.
// Drives sample beats and register writes, predicts every result beat and compares it.
// Depends on cpsp_pkg, cpsp_if and the cascaded_position_speed_pid_unit top level.
`timescale 1ns / 1ps

module cascaded_position_speed_pid_unit_test;
	import cpsp_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_TICKS   = 205;
	localparam int IDLE_PCT      = 9;
	localparam int LOOP_POS      = 0;
	localparam int LOOP_SPD      = 1;

	typedef struct {
		int motor;
		int sref;
		int speed;
	} tick_out_t;

	class cascade_tracker;
		logic [GAINS_W-1:0]  pos_gains, spd_gains;
		logic [ILIM_W-1:0]   pos_ilim, spd_ilim;
		logic [LIMITS_W-1:0] pos_limits, spd_limits;
		bit                  cascade;
		int                  prev_err[2];
		int                  integral[2];
		int                  prev_out[2];
		int                  prev_pos;
		tick_out_t           want_q[$];
		int                  fails;

		function new();
			pos_gains = '0; spd_gains = '0;
			pos_ilim = '0; spd_ilim = '0;
			pos_limits = '0; spd_limits = '0;
			cascade = 1'b1;
			prev_err = '{0, 0};
			integral = '{0, 0};
			prev_out = '{0, 0};
			prev_pos = 0;
			fails = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_POS_GAINS:  pos_gains = data[GAINS_W-1:0];
				REG_POS_ILIM:   pos_ilim = data[ILIM_W-1:0];
				REG_POS_LIMITS: pos_limits = data[LIMITS_W-1:0];
				REG_SPD_GAINS:  spd_gains = data[GAINS_W-1:0];
				REG_SPD_ILIM:   spd_ilim = data[ILIM_W-1:0];
				REG_SPD_LIMITS: spd_limits = data[LIMITS_W-1:0];
				REG_CASCADE:    cascade = data[0];
				default: ;
			endcase
		endfunction

		function int gain_of(logic [GAINS_W-1:0] gains, int lsb);
			logic signed [GAIN_W-1:0] g;
			g = gains[lsb +: GAIN_W];
			return int'(g);
		endfunction

		function int run_pid(int lp, logic [GAINS_W-1:0] gains, logic [ILIM_W-1:0] ilim_reg,
				logic [LIMITS_W-1:0] limits, int err);
			int kp, ki, kd, ilim, spd, acc, d, iterm, cmd;
			kp = gain_of(gains, KP_LSB);
			ki = gain_of(gains, KI_LSB);
			kd = gain_of(gains, KD_LSB);
			ilim = int'({1'b0, ilim_reg});
			spd = int'({16'd0, limits[SPD_LSB +: LIMIT_W]});
			acc = int'({16'd0, limits[ACC_LSB +: LIMIT_W]});
			d = err - prev_err[lp];
			prev_err[lp] = err;
			integral[lp] = integral[lp] + err;
			if (ki != 0) begin
				if (integral[lp] > ilim)
					integral[lp] = ilim;
				else if (integral[lp] < -ilim)
					integral[lp] = -ilim;
			end
			iterm = (integral[lp] * ki) / 100;
			cmd = err * kp + iterm - d * kd;
			if (spd != 0) begin
				if (cmd > spd)
					cmd = spd;
				else if (cmd < -spd)
					cmd = -spd;
			end
			if (acc != 0) begin
				if (cmd - prev_out[lp] > acc)
					cmd = prev_out[lp] + acc;
				else if (prev_out[lp] - cmd > acc)
					cmd = prev_out[lp] - acc;
			end
			prev_out[lp] = cmd;
			return cmd;
		endfunction

		function void take_tick(int enc, int tgt);
			tick_out_t t;
			t.speed = enc - prev_pos;
			t.sref = run_pid(LOOP_POS, pos_gains, pos_ilim, pos_limits, tgt - enc);
			if (cascade)
				t.motor = run_pid(LOOP_SPD, spd_gains, spd_ilim, spd_limits, t.sref - t.speed);
			else
				t.motor = t.sref;
			prev_pos = enc;
			want_q.push_back(t);
		endfunction

		function void compare_field(string name, logic [FIELD_W-1:0] got, int want);
			if (got !== want) begin
				$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want,
					$signed(got));
				fails++;
			end
		endfunction

		function void match_result(logic [FIELD_W-1:0] motor, logic [FIELD_W-1:0] sref,
				logic [FIELD_W-1:0] speed);
			tick_out_t t;
			if (want_q.size() == 0) begin
				$display("%0t unexpected result beat: expected none actual %0d %0d %0d", $time,
					$signed(motor), $signed(sref), $signed(speed));
				fails++;
			end else begin
				t = want_q.pop_front();
				compare_field("motor_command", motor, t.motor);
				compare_field("speed_reference", sref, t.sref);
				compare_field("measured_speed", speed, t.speed);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	bit                     steady;
	cascade_tracker         tracker;

	cpsp_in_if  sample_ch();
	cpsp_out_if result_ch();

	cascaded_position_speed_pid_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic send_tick(input int enc, input int tgt);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.encoder_position <= enc;
		sample_ch.target_position <= tgt;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		tracker.take_tick(enc, tgt);
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (tracker.want_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic apply_settings(input logic [31:0] pg, input logic [31:0] pil,
			input logic [31:0] pl, input logic [31:0] sg, input logic [31:0] sil,
			input logic [31:0] sl, input logic [31:0] casc);
		wait_idle();
		put_reg(REG_POS_GAINS, pg);
		put_reg(REG_POS_ILIM, pil);
		put_reg(REG_POS_LIMITS, pl);
		put_reg(REG_SPD_GAINS, sg);
		put_reg(REG_SPD_ILIM, sil);
		put_reg(REG_SPD_LIMITS, sl);
		put_reg(REG_CASCADE, casc);
		put_reg(REG_UNUSED, $urandom);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [31:0] pick_gains();
		logic [GAINS_W-1:0] g;
		if ($urandom_range(0, 1)) begin
			g = GAINS_W'($urandom);
		end else begin
			g[KP_LSB +: GAIN_W] = 8'(int'($urandom_range(0, 16)) - 8);
			g[KI_LSB +: GAIN_W] = 8'(int'($urandom_range(0, 16)) - 8);
			g[KD_LSB +: GAIN_W] = 8'(int'($urandom_range(0, 16)) - 8);
		end
		return {8'($urandom), g};
	endfunction

	function automatic logic [31:0] pick_ilim();
		logic [ILIM_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = 31'($urandom_range(1, 5000));
			2: v = '1;
			default: v = ILIM_W'($urandom);
		endcase
		return {1'($urandom), v};
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'($urandom);
			default: return 16'($urandom_range(1, 2000));
		endcase
	endfunction

	task automatic run_random_phase(input int count);
		int plant, goal, enc, tgt, r;
		plant = $urandom;
		goal = plant;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				// servo-like tracking: the position closes in on a target that moves now and then
				if ($urandom_range(0, 9) == 0)
					goal = plant + int'($urandom_range(0, 20000)) - 10000;
				plant = plant + (goal - plant) / 16 + int'($urandom_range(0, 16)) - 8;
				enc = plant;
				tgt = goal;
			end else if (r < 92) begin
				enc = $urandom;
				tgt = $urandom;
			end else begin
				enc = 32'h7FFF_FFFF - int'($urandom_range(0, 255));
				tgt = enc + 32'h8000_0000 + int'($urandom_range(0, 255)) - 128;
				if ($urandom_range(0, 1))
					enc = ~enc;
			end
			send_tick(enc, tgt);
		end
	endtask

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				tracker.match_result(result_ch.motor_command, result_ch.speed_reference,
					result_ch.measured_speed);
			result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				stall = 0;
			else
				stall++;
			if (stall >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		tracker = new();
		steady = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.encoder_position = '0;
		sample_ch.target_position = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings after reset
		send_tick(0, 0);
		send_tick(32'h7FFF_FFFF, 32'h8000_0000);

		// integral with KI zero runs unclamped; speed loop at its extreme gains
		apply_settings(32'h0000_0001, 32'd5, 32'h0, 32'h007F_807F, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'd1);
		send_tick(32'h8000_0000, 32'h7FFF_FFFF);
		send_tick(32'h7FFF_FFFF, 32'h8000_0000);
		send_tick(0, 1000);
		send_tick(0, 1000);
		send_tick(0, 1000);
		send_tick(-1, 0);
		send_tick(1, -1);
		send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF);

		// direct drive with speed clamp and slew on the position loop
		apply_settings(32'h0080_FF7F, 32'd1000, 32'h0010_0064, 32'h0001_0203, 32'd50,
			32'h0, 32'd0);
		send_tick(0, 5000);
		send_tick(0, 5000);
		send_tick(0, -5000);
		send_tick(0, -5000);
		send_tick(0, 0);
		send_tick(100, 0);
		send_tick(32'h8000_0000, 0);
		send_tick(0, 32'h7FFF_FFFF);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: apply_settings(32'h0080_7F80, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0080_7F80,
					32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1);
				1: apply_settings(pick_gains(), 32'd0, 32'd0, pick_gains(), 32'd0, 32'd0, 32'd0);
				2: apply_settings(32'h007F_807F, 32'd0, 32'h0001_0001, 32'h00FF_FFFF, 32'd0,
					32'h0001_0001, 32'd1);
				default: apply_settings(pick_gains(), pick_ilim(), {pick_limit(), pick_limit()},
					pick_gains(), pick_ilim(), {pick_limit(), pick_limit()}, $urandom);
			endcase
			steady = (p == 3);
			run_random_phase(PHASE_TICKS);
		end
		steady = 1'b0;

		wait_idle();
		if (tracker.fails == 0 && tracker.want_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[cascaded_position_speed_pid_unit.f]
rtl/cpsp_pkg.sv
rtl/cpsp_if.sv
rtl/cpsp_regs.sv
rtl/cpsp_loop.sv
rtl/cascaded_position_speed_pid_unit.sv
verif/cascaded_position_speed_pid_unit_test.sv
